// ----- hw/rtl/rc_pulse_light_controller_top_defines.svh -----
// ----------------------------------------------------------------------------
// RC pulse light controller - assertion macros
// Shared property wrappers for the checker of the controller top level.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_LIGHT_CONTROLLER_TOP_DEFINES_SVH
`define RC_PULSE_LIGHT_CONTROLLER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RCPLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define RCPLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rcplc_pkg.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - package
// Widths, register map, light modes and shared helper functions.
// ----------------------------------------------------------------------------
package rcplc_pkg;

    // Pulse width counter
    localparam int WIDTH_BITS   = 16;
    localparam int LAST_WIDTH_W = 16;
    localparam int CMP_W        = (WIDTH_BITS > LAST_WIDTH_W) ? WIDTH_BITS : LAST_WIDTH_W;

    // Configuration widths
    localparam int PRESCALE_W     = 11;
    localparam int PRESCALE_CNT_W = 10;
    localparam int THRESH_W       = 16;
    localparam int PERIOD_W       = 16;
    localparam int PHASE_W        = 2;
    localparam int MODE_W         = 3;

    // APB register map
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [PRESCALE_W-1:0] PRESCALE_MIN = PRESCALE_W'(1);
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = PRESCALE_W'(1024);

    localparam logic [PRESCALE_W-1:0] RST_TICK_PRESCALE = PRESCALE_W'(16);
    localparam logic [THRESH_W-1:0]   RST_ON_THRESHOLD  = THRESH_W'(1200);
    localparam logic [THRESH_W-1:0]   RST_OFF_THRESHOLD = THRESH_W'(1800);
    localparam logic [PERIOD_W-1:0]   RST_LONG_PERIOD   = PERIOD_W'(62490);
    localparam logic [PERIOD_W-1:0]   RST_SHORT_PERIOD  = PERIOD_W'(6249);

    localparam logic [PHASE_W-1:0] PHASE_LONG = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TICK_PRESCALE = 3'd0,
        REG_ON_THRESHOLD  = 3'd1,
        REG_OFF_THRESHOLD = 3'd2,
        REG_LONG_PERIOD   = 3'd3,
        REG_SHORT_PERIOD  = 3'd4
    } reg_idx_t;

    // Light mode bits and codes
    localparam int MODE_NAV_BIT     = 0;
    localparam int MODE_STROBE_BIT  = 1;
    localparam int MODE_LANDING_BIT = 2;

    localparam logic [MODE_W-1:0] MODE_ALL_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NAV_STROBE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALL_ON     = 3'd7;

    typedef struct packed {
        logic [PRESCALE_W-1:0] tick_prescale;
        logic [THRESH_W-1:0]   on_threshold;
        logic [THRESH_W-1:0]   off_threshold;
        logic [PERIOD_W-1:0]   long_period;
        logic [PERIOD_W-1:0]   short_period;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [WIDTH_BITS-1:0] width;
    } light_t;

    function automatic logic [MODE_W-1:0] classify(
        input logic [WIDTH_BITS-1:0] w,
        input logic [THRESH_W-1:0]   on_thr,
        input logic [THRESH_W-1:0]   off_thr
    );
        logic [CMP_W-1:0] wx;
        logic [CMP_W-1:0] onx;
        logic [CMP_W-1:0] offx;
        wx   = CMP_W'(w);
        onx  = CMP_W'(on_thr);
        offx = CMP_W'(off_thr);
        if (wx < onx) begin
            return MODE_ALL_ON;
        end else if (wx > offx) begin
            return MODE_ALL_OFF;
        end
        return MODE_NAV_STROBE;
    endfunction

    // Clamp a counter width onto the 16-bit result field
    function automatic logic [LAST_WIDTH_W-1:0] sat_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS+LAST_WIDTH_W-1:0] wx;
        wx = (WIDTH_BITS+LAST_WIDTH_W)'(w);
        if (|wx[WIDTH_BITS+LAST_WIDTH_W-1:LAST_WIDTH_W]) begin
            return '1;
        end
        return wx[LAST_WIDTH_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rcplc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - configuration registers
// APB write and read access to the five control registers.
// ----------------------------------------------------------------------------
module rcplc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcplc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rcplc_pkg::DATA_W-1:0]  pwdata,
    output logic [rcplc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output rcplc_pkg::cfg_t               cfg
);

    rcplc_pkg::cfg_t                      cfg_reg;
    rcplc_pkg::cfg_t                      cfg_next;
    logic [rcplc_pkg::REG_IDX_W-1:0]      idx;
    logic                                 wr_en;

    assign idx    = paddr[rcplc_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                rcplc_pkg::REG_TICK_PRESCALE:
                    cfg_next.tick_prescale = pwdata[rcplc_pkg::PRESCALE_W-1:0];
                rcplc_pkg::REG_ON_THRESHOLD:
                    cfg_next.on_threshold = pwdata[rcplc_pkg::THRESH_W-1:0];
                rcplc_pkg::REG_OFF_THRESHOLD:
                    cfg_next.off_threshold = pwdata[rcplc_pkg::THRESH_W-1:0];
                rcplc_pkg::REG_LONG_PERIOD:
                    cfg_next.long_period = pwdata[rcplc_pkg::PERIOD_W-1:0];
                rcplc_pkg::REG_SHORT_PERIOD:
                    cfg_next.short_period = pwdata[rcplc_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rcplc_pkg::REG_TICK_PRESCALE:
                prdata = rcplc_pkg::DATA_W'(cfg_reg.tick_prescale);
            rcplc_pkg::REG_ON_THRESHOLD:
                prdata = rcplc_pkg::DATA_W'(cfg_reg.on_threshold);
            rcplc_pkg::REG_OFF_THRESHOLD:
                prdata = rcplc_pkg::DATA_W'(cfg_reg.off_threshold);
            rcplc_pkg::REG_LONG_PERIOD:
                prdata = rcplc_pkg::DATA_W'(cfg_reg.long_period);
            rcplc_pkg::REG_SHORT_PERIOD:
                prdata = rcplc_pkg::DATA_W'(cfg_reg.short_period);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_prescale <= rcplc_pkg::RST_TICK_PRESCALE;
            cfg_reg.on_threshold  <= rcplc_pkg::RST_ON_THRESHOLD;
            cfg_reg.off_threshold <= rcplc_pkg::RST_OFF_THRESHOLD;
            cfg_reg.long_period   <= rcplc_pkg::RST_LONG_PERIOD;
            cfg_reg.short_period  <= rcplc_pkg::RST_SHORT_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/rcplc_pulse_decode.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - pulse decoder
// Measures the high time of each receiver pulse and picks the light mode.
// ----------------------------------------------------------------------------
module rcplc_pulse_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                level,
    input  rcplc_pkg::cfg_t     cfg,
    output rcplc_pkg::light_t   light_next
);

    logic                                  prev_level_reg;
    logic                                  prev_level_next;
    logic                                  rise_seen_reg;
    logic                                  rise_seen_next;
    logic [rcplc_pkg::WIDTH_BITS-1:0]      high_count_reg;
    logic [rcplc_pkg::WIDTH_BITS-1:0]      high_count_next;
    rcplc_pkg::light_t                     light_reg;

    always_comb begin
        rise_seen_next  = rise_seen_reg;
        high_count_next = high_count_reg;
        light_next      = light_reg;
        prev_level_next = level;
        if (level && !prev_level_reg) begin
            rise_seen_next  = 1'b1;
            high_count_next = rcplc_pkg::WIDTH_BITS'(1);
        end else if (level && prev_level_reg) begin
            // saturate at full scale
            if (high_count_reg != '1) begin
                high_count_next = high_count_reg + 1'b1;
            end
        end else if (!level && prev_level_reg && rise_seen_reg) begin
            light_next.width = high_count_reg;
            light_next.mode  = rcplc_pkg::classify(high_count_reg, cfg.on_threshold,
                                                   cfg.off_threshold);
            rise_seen_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg   <= 1'b0;
            rise_seen_reg    <= 1'b0;
            high_count_reg   <= '0;
            light_reg.width  <= '0;
            light_reg.mode   <= rcplc_pkg::MODE_ALL_OFF;
        end else if (en) begin
            prev_level_reg   <= prev_level_next;
            rise_seen_reg    <= rise_seen_next;
            high_count_reg   <= high_count_next;
            light_reg        <= light_next;
        end
    end

endmodule

// ----- hw/rtl/rcplc_strobe_timer.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - strobe timer
// Prescaled timer running one long and three short phases, toggling the strobe.
// ----------------------------------------------------------------------------
module rcplc_strobe_timer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                strobe_enable,
    input  rcplc_pkg::cfg_t     cfg,
    output logic                strobe_next
);

    logic [rcplc_pkg::PRESCALE_CNT_W-1:0]  prescale_count_reg;
    logic [rcplc_pkg::PRESCALE_CNT_W-1:0]  prescale_count_next;
    logic [rcplc_pkg::PERIOD_W-1:0]        period_count_reg;
    logic [rcplc_pkg::PERIOD_W-1:0]        period_count_next;
    logic [rcplc_pkg::PHASE_W-1:0]         phase_index_reg;
    logic [rcplc_pkg::PHASE_W-1:0]         phase_index_next;
    logic                                  strobe_level_reg;
    logic [rcplc_pkg::PRESCALE_W-1:0]      pre;
    logic [rcplc_pkg::PRESCALE_W-1:0]      pre_inc;
    logic [rcplc_pkg::PERIOD_W-1:0]        cmp;

    always_comb begin
        // clamp the prescale into its legal range
        if (cfg.tick_prescale == '0) begin
            pre = rcplc_pkg::PRESCALE_MIN;
        end else if (cfg.tick_prescale > rcplc_pkg::PRESCALE_MAX) begin
            pre = rcplc_pkg::PRESCALE_MAX;
        end else begin
            pre = cfg.tick_prescale;
        end
        pre_inc = rcplc_pkg::PRESCALE_W'(prescale_count_reg) + 1'b1;
        cmp     = (phase_index_reg == rcplc_pkg::PHASE_LONG) ? cfg.long_period
                                                             : cfg.short_period;

        prescale_count_next = pre_inc[rcplc_pkg::PRESCALE_CNT_W-1:0];
        period_count_next   = period_count_reg;
        phase_index_next    = phase_index_reg;
        strobe_next         = strobe_level_reg;
        if (pre_inc >= pre) begin
            prescale_count_next = '0;
            if (period_count_reg >= cmp) begin
                period_count_next = '0;
                strobe_next       = strobe_enable ? ~strobe_level_reg : 1'b0;
                phase_index_next  = phase_index_reg + 1'b1;
            end else begin
                period_count_next = period_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            phase_index_reg    <= rcplc_pkg::PHASE_LONG;
            strobe_level_reg   <= 1'b0;
        end else if (en) begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            phase_index_reg    <= phase_index_next;
            strobe_level_reg   <= strobe_next;
        end
    end

endmodule

// ----- hw/rtl/rc_pulse_light_controller_top.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - top level
// Decodes RC servo pulses into navigation, landing and strobe light drives.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per microsecond tick, s_tdata[0] is the sampled
//   receiver level. m_ channel: one result item per input item, carrying
//   the three light drives and the most recent measured pulse width.
//   APB port: five registers at byte addresses 0, 4, 8, 12 and 16 (prescale,
//   on threshold, off threshold, long period, short period); write only
//   while no item is in flight.
//   An accepted item sits in the input register, then decode and timer
//   update load the result register once the output side can advance.
//   Throughput: one item per cycle; while a result waits to be taken the
//   input register takes one more item and then holds it.
//   When the receiver stalls, the result register holds, the input register
//   fills and s_tready drops until the result is taken.
//   Reset (aresetn low, synchronous) empties the pipeline, clears all
//   decoder and timer state to lights off and loads the register defaults.
// ----------------------------------------------------------------------------
module rc_pulse_light_controller_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [0] rx_level, [7:1] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    // m_tdata: [0] nav_light, [1] landing_light, [2] strobe_light,
    //          [18:3] last_width, [23:19] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcplc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rcplc_pkg::DATA_W-1:0]  pwdata,
    output logic [rcplc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    rcplc_pkg::cfg_t                          cfg;
    rcplc_pkg::light_t                        light_next;
    logic                                     strobe_next;

    logic                                     in_valid_reg;
    logic                                     in_level_reg;
    logic                                     m_valid_reg;
    logic                                     nav_reg;
    logic                                     landing_reg;
    logic                                     strobe_reg;
    logic [rcplc_pkg::LAST_WIDTH_W-1:0]       last_width_reg;
    logic                                     advance;
    logic                                     proc_en;

    assign advance  = ~m_valid_reg | m_tready;
    assign proc_en  = in_valid_reg & advance;
    assign s_tready = ~in_valid_reg | advance;

    rcplc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcplc_pulse_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (proc_en),
        .level      (in_level_reg),
        .cfg        (cfg),
        .light_next (light_next)
    );

    rcplc_strobe_timer u_timer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (proc_en),
        .strobe_enable (light_next.mode[rcplc_pkg::MODE_STROBE_BIT]),
        .cfg           (cfg),
        .strobe_next   (strobe_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (proc_en) begin
            nav_reg        <= light_next.mode[rcplc_pkg::MODE_NAV_BIT];
            landing_reg    <= light_next.mode[rcplc_pkg::MODE_LANDING_BIT];
            strobe_reg     <= strobe_next;
            last_width_reg <= rcplc_pkg::sat_width(light_next.width);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, last_width_reg, strobe_reg, landing_reg, nav_reg};

endmodule

// ----- hw/rtl/rcplc_checker.sv -----
// ----------------------------------------------------------------------------
// RC pulse light controller - port checker
// Watches the top level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "rc_pulse_light_controller_top_defines.svh"

module rcplc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata
);

    // hold a stalled result
    `RCPLC_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result not held")
    // landing light only ever comes on together with the nav light
    `RCPLC_ASSERT(a_landing_needs_nav, m_tvalid && m_tdata[1] |-> m_tdata[0], "landing without nav")
    // a free output side never blocks the input
    `RCPLC_ASSERT(a_no_block, !m_tvalid |-> s_tready, "input stalled with empty output")
    // reset empties the output
    `RCPLC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind rc_pulse_light_controller_top rcplc_checker u_rcplc_checker (.*);
